// ===== design/irec_pkg.sv =====
// ----------------------------------------------------------------------------
// irec_pkg: shared types and constants
// Character classes, request layout, scan scopes and result codes for the
// if-statement recognizer.
// ----------------------------------------------------------------------------
package irec_pkg;

    // request commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_SCAN    = 1'b1;

    // fixed field widths
    localparam int unsigned SYM_W = 8;
    localparam int unsigned IO_POS_W = 16;

    // characters of interest
    localparam logic [SYM_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [SYM_W-1:0] CH_TAB    = 8'h09;
    localparam logic [SYM_W-1:0] CH_LF     = 8'h0A;
    localparam logic [SYM_W-1:0] CH_CR     = 8'h0D;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [SYM_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [SYM_W-1:0] CH_I      = 8'h69;
    localparam logic [SYM_W-1:0] CH_F      = 8'h66;

    // status codes
    localparam logic [1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_READY     = 2'd2;

    // branch kinds
    localparam logic [1:0] BR_UNDEF      = 2'd0;
    localparam logic [1:0] BR_TRUE_ONLY  = 2'd1;
    localparam logic [1:0] BR_TRUE_FALSE = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_RPAREN      = 3'd1;
    localparam logic [2:0] ERR_AFTER_IF    = 3'd2;
    localparam logic [2:0] ERR_RBRACE_TRUE = 3'd3;
    localparam logic [2:0] ERR_AFTER_COND  = 3'd4;
    localparam logic [2:0] ERR_RBRACE_FALS = 3'd5;
    localparam logic [2:0] ERR_BEFORE_FALS = 3'd6;
    localparam logic [2:0] ERR_TOO_DEEP    = 3'd7;

    // bound slots
    localparam int unsigned BD_COND_START  = 0;
    localparam int unsigned BD_COND_END    = 1;
    localparam int unsigned BD_TRUE_START  = 2;
    localparam int unsigned BD_TRUE_END    = 3;
    localparam int unsigned BD_FALSE_START = 4;
    localparam int unsigned BD_FALSE_END   = 5;
    localparam int unsigned BD_COUNT       = 6;

    // request queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_CW    = 3;

    typedef enum logic [2:0] {
        SC_KEY,
        SC_COND,
        SC_TRUE,
        SC_FALSE,
        SC_WEAVE
    } t_scope;

    typedef enum logic [1:0] {
        TM_IDLE,
        TM_OPEN,
        TM_CLOSED
    } t_tmode;

    typedef struct packed {
        logic ws;
        logic lparen;
        logic rparen;
        logic lbrace;
        logic rbrace;
        logic colon;
    } t_sym_class;

    typedef struct packed {
        logic                command;
        logic [SYM_W-1:0]    symbol;
        logic [IO_POS_W-1:0] position;
        t_sym_class          cls;
    } t_req;

endpackage

// ===== design/irec_front.sv =====
// ----------------------------------------------------------------------------
// irec_front: request intake
// Accepts requests, classifies the character and pushes them to the queue.
// ----------------------------------------------------------------------------
module irec_front (
    input  logic                         i_valid,
    input  logic                         i_command,
    input  logic [7:0]                   i_symbol,
    input  logic [15:0]                  i_position,
    input  logic                         i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output irec_pkg::t_req               o_req
);
    import irec_pkg::*;

    t_sym_class cls;

    always_comb begin
        cls.ws     = (i_symbol == CH_SPACE) || (i_symbol == CH_TAB) ||
                     (i_symbol == CH_LF) || (i_symbol == CH_CR);
        cls.lparen = (i_symbol == CH_LPAREN);
        cls.rparen = (i_symbol == CH_RPAREN);
        cls.lbrace = (i_symbol == CH_LBRACE);
        cls.rbrace = (i_symbol == CH_RBRACE);
        cls.colon  = (i_symbol == CH_COLON);
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign o_req.command  = i_command;
    assign o_req.symbol   = i_symbol;
    assign o_req.position = i_position;
    assign o_req.cls      = cls;

endmodule

// ===== design/irec_queue.sv =====
// ----------------------------------------------------------------------------
// irec_queue: request queue
// Small FIFO between intake and scanner; push and pop in the same cycle, but a push into a full queue is refused.
// ----------------------------------------------------------------------------
module irec_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  irec_pkg::t_req      i_req,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output irec_pkg::t_req      o_req
);
    import irec_pkg::*;

    t_req            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_AW-1:0] n_wr_ptr;
    logic [Q_AW-1:0] n_rd_ptr;
    logic [Q_CW-1:0] n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// ===== design/irec_back.sv =====
// ----------------------------------------------------------------------------
// irec_back: scanner
// Steps the recognizer state by one request; the state registers double as
// the result register, held while the receiver stalls.
// ----------------------------------------------------------------------------
module irec_back #(
    parameter int unsigned POS_WIDTH   = 16,
    parameter int unsigned DEPTH_WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  irec_pkg::t_req      i_req,
    input  logic                i_stall,
    output logic                o_pop,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [2:0]          o_error_code,
    output logic [1:0]          o_branch_kind,
    output logic [15:0]         o_cond_start,
    output logic [15:0]         o_cond_end,
    output logic [15:0]         o_true_start,
    output logic [15:0]         o_true_end,
    output logic [15:0]         o_false_start,
    output logic [15:0]         o_false_end
);
    import irec_pkg::*;

    t_scope                 r_scope,  n_scope;
    logic                   r_main,   n_main;
    logic [POS_WIDTH-1:0]   r_tok,    n_tok;
    logic [15:0]            r_first,  n_first;
    logic                   r_cmode,  n_cmode;
    logic [DEPTH_WIDTH-1:0] r_pdepth, n_pdepth;
    t_tmode                 r_tmode,  n_tmode;
    logic [DEPTH_WIDTH-1:0] r_tdepth, n_tdepth;
    logic                   r_fmode,  n_fmode;
    logic [DEPTH_WIDTH-1:0] r_fdepth, n_fdepth;
    logic [POS_WIDTH-1:0]   r_bounds [BD_COUNT];
    logic [POS_WIDTH-1:0]   n_bounds [BD_COUNT];
    logic [1:0]             r_branch, n_branch;
    logic [1:0]             r_status, n_status;
    logic [2:0]             r_error,  n_error;
    logic                   r_out_valid;

    logic [POS_WIDTH-1:0]   pos;
    logic [POS_WIDTH-1:0]   pos_p1;
    logic [POS_WIDTH-1:0]   off;
    logic                   brk;
    t_sym_class             cls;

    // one step per cycle while the result slot is free or being taken
    assign o_pop   = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;

    assign cls    = i_req.cls;
    assign pos    = POS_WIDTH'(i_req.position);
    assign pos_p1 = pos + 1'b1;

    always_comb begin
        n_scope  = r_scope;
        n_main   = r_main;
        n_tok    = r_tok;
        n_first  = r_first;
        n_cmode  = r_cmode;
        n_pdepth = r_pdepth;
        n_tmode  = r_tmode;
        n_tdepth = r_tdepth;
        n_fmode  = r_fmode;
        n_fdepth = r_fdepth;
        n_bounds = r_bounds;
        n_branch = r_branch;
        n_status = r_status;
        n_error  = r_error;
        off      = '0;
        brk      = 1'b0;

        if (i_req.command == CMD_RESTART) begin
            n_scope  = SC_KEY;
            n_main   = 1'b0;
            n_tok    = pos;
            n_first  = '0;
            n_cmode  = 1'b0;
            n_pdepth = '0;
            n_tmode  = TM_IDLE;
            n_tdepth = '0;
            n_fmode  = 1'b0;
            n_fdepth = '0;
            for (int i = 0; i < BD_COUNT; i++) begin
                n_bounds[i] = '0;
            end
            n_branch = BR_UNDEF;
            n_status = ST_NOT_FOUND;
            n_error  = ERR_NONE;
        end else if (r_error == ERR_NONE) begin
            // leading whitespace advances the token start
            if (!r_main) begin
                if (cls.ws) begin
                    n_tok = r_tok + 1'b1;
                end else begin
                    n_main = 1'b1;
                end
            end
            if (n_main) begin
                if (n_scope == SC_KEY) begin
                    off = pos - n_tok;
                    if (off == POS_WIDTH'(0)) begin
                        n_first[7:0] = i_req.symbol;
                    end else if (off == POS_WIDTH'(1)) begin
                        n_first[15:8] = i_req.symbol;
                    end
                    if ((cls.ws || cls.lparen) && off == POS_WIDTH'(2) &&
                        n_first[7:0] == CH_I && n_first[15:8] == CH_F) begin
                        n_tok    = pos;
                        n_main   = 1'b0;
                        n_scope  = SC_COND;
                        n_status = ST_FOUND;
                    end
                end
                case (n_scope)
                    SC_COND: begin
                        if (cls.lparen) begin
                            if (&r_pdepth) begin
                                n_error = ERR_TOO_DEEP;
                            end else begin
                                if (!r_cmode) begin
                                    n_bounds[BD_COND_START] = pos_p1;
                                    n_cmode = 1'b1;
                                end
                                n_pdepth = r_pdepth + 1'b1;
                            end
                        end else if (cls.rparen) begin
                            if (!r_cmode) begin
                                n_error = ERR_RPAREN;
                            end else begin
                                n_pdepth = r_pdepth - 1'b1;
                                if (n_pdepth == '0) begin
                                    n_bounds[BD_COND_END] = pos;
                                    n_tok   = pos_p1;
                                    n_main  = 1'b0;
                                    n_scope = SC_TRUE;
                                end
                            end
                        end else if (!cls.ws && !r_cmode) begin
                            n_error = ERR_AFTER_IF;
                        end
                    end
                    SC_TRUE: begin
                        if (cls.lbrace && r_tmode != TM_CLOSED) begin
                            if (&r_tdepth) begin
                                n_error = ERR_TOO_DEEP;
                                brk     = 1'b1;
                            end else begin
                                if (r_tmode == TM_IDLE) begin
                                    n_bounds[BD_TRUE_START] = pos;
                                    n_tmode = TM_OPEN;
                                end
                                n_tdepth = r_tdepth + 1'b1;
                            end
                        end
                        if (!brk && cls.rbrace) begin
                            if (n_tmode == TM_IDLE) begin
                                n_error = ERR_RBRACE_TRUE;
                                brk     = 1'b1;
                            end else if (n_tmode == TM_OPEN) begin
                                n_tdepth = n_tdepth - 1'b1;
                                if (n_tdepth == '0) begin
                                    n_bounds[BD_TRUE_END] = pos_p1;
                                    n_tmode = TM_CLOSED;
                                    brk     = 1'b1;
                                end
                            end
                        end
                        if (!brk && !cls.ws) begin
                            if (n_tmode == TM_IDLE) begin
                                n_error = ERR_AFTER_COND;
                            end else if (n_tmode == TM_CLOSED) begin
                                if (cls.colon) begin
                                    n_branch = BR_TRUE_FALSE;
                                    n_scope  = SC_FALSE;
                                end else begin
                                    n_branch = BR_TRUE_ONLY;
                                    n_scope  = SC_WEAVE;
                                    n_status = ST_READY;
                                end
                                n_tok  = pos_p1;
                                n_main = 1'b0;
                            end
                        end
                    end
                    SC_FALSE: begin
                        if (cls.lbrace) begin
                            if (&r_fdepth) begin
                                n_error = ERR_TOO_DEEP;
                                brk     = 1'b1;
                            end else begin
                                if (!r_fmode) begin
                                    n_bounds[BD_FALSE_START] = pos;
                                    n_fmode = 1'b1;
                                end
                                n_fdepth = r_fdepth + 1'b1;
                            end
                        end
                        if (!brk && cls.rbrace) begin
                            if (!n_fmode) begin
                                n_error = ERR_RBRACE_FALS;
                                brk     = 1'b1;
                            end else begin
                                n_fdepth = n_fdepth - 1'b1;
                                if (n_fdepth == '0) begin
                                    n_bounds[BD_FALSE_END] = pos_p1;
                                    n_scope  = SC_WEAVE;
                                    n_status = ST_READY;
                                    n_tok    = pos_p1;
                                    n_main   = 1'b0;
                                end
                            end
                        end
                        if (!brk && !cls.ws && !n_fmode) begin
                            n_error = ERR_BEFORE_FALS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scope     <= SC_KEY;
            r_main      <= 1'b0;
            r_tok       <= '0;
            r_first     <= '0;
            r_cmode     <= 1'b0;
            r_pdepth    <= '0;
            r_tmode     <= TM_IDLE;
            r_tdepth    <= '0;
            r_fmode     <= 1'b0;
            r_fdepth    <= '0;
            for (int i = 0; i < BD_COUNT; i++) begin
                r_bounds[i] <= '0;
            end
            r_branch    <= BR_UNDEF;
            r_status    <= ST_NOT_FOUND;
            r_error     <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_scope  <= n_scope;
                r_main   <= n_main;
                r_tok    <= n_tok;
                r_first  <= n_first;
                r_cmode  <= n_cmode;
                r_pdepth <= n_pdepth;
                r_tmode  <= n_tmode;
                r_tdepth <= n_tdepth;
                r_fmode  <= n_fmode;
                r_fdepth <= n_fdepth;
                r_bounds <= n_bounds;
                r_branch <= n_branch;
                r_status <= n_status;
                r_error  <= n_error;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status      = r_status;
    assign o_error_code  = r_error;
    assign o_branch_kind = r_branch;
    assign o_cond_start  = 16'(r_bounds[BD_COND_START]);
    assign o_cond_end    = 16'(r_bounds[BD_COND_END]);
    assign o_true_start  = 16'(r_bounds[BD_TRUE_START]);
    assign o_true_end    = 16'(r_bounds[BD_TRUE_END]);
    assign o_false_start = 16'(r_bounds[BD_FALSE_START]);
    assign o_false_end   = 16'(r_bounds[BD_FALSE_END]);

endmodule

// ===== design/if_statement_recognizer.sv =====
// ----------------------------------------------------------------------------
// if_statement_recognizer: streaming if/else statement recognizer
// Scans source text one character per request and reports the condition
// and body bounds of an if statement with an optional false branch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): each request is either a restart
//   (i_command = 0, position in i_position) or one scanned character
//   (i_command = 1, byte in i_symbol at i_position).
//   Output channel (o_valid / i_stall): exactly one result per request,
//   in order: status, sticky error code, branch kind and six bounds as
//   they stand after that request.
//   A request popped from the queue updates the scanner registers, which
//   then drive the result outputs.
//   Throughput: one request per cycle while no pending result is held by
//   i_stall, set by the scanner step on the scope and depth registers.
//   A 4-entry queue sits between intake and scanner; o_stall rises only
//   when it is full. While i_stall holds a pending result, it stays put
//   and the scanner waits; intake keeps filling the queue.
//   Reset (synchronous, active low) empties the queue, drops o_valid and
//   returns the scanner to keyword scope with all bounds at zero.
//   Once an error is reported, character requests leave the result
//   unchanged until a restart request arrives.
// ----------------------------------------------------------------------------
module if_statement_recognizer #(
    parameter int unsigned POS_WIDTH   = 16,
    parameter int unsigned DEPTH_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_symbol,
    input  logic [15:0] i_position,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_error_code,
    output logic [1:0]  o_branch_kind,
    output logic [15:0] o_cond_start,
    output logic [15:0] o_cond_end,
    output logic [15:0] o_true_start,
    output logic [15:0] o_true_end,
    output logic [15:0] o_false_start,
    output logic [15:0] o_false_end
);
    import irec_pkg::*;

    t_req    front_req;
    t_req    q_req;
    logic    front_push;
    logic    q_full;
    logic    q_valid;
    logic    back_pop;

    // intake: classify the character, stall only on a full queue
    irec_front u_front (
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_symbol   (i_symbol),
        .i_position (i_position),
        .i_full     (q_full),
        .o_stall    (o_stall),
        .o_push     (front_push),
        .o_req      (front_req)
    );

    // decoupling queue between intake and scanner
    irec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_req   (front_req),
        .i_pop   (back_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    // scanner: one state step per popped request
    irec_back #(
        .POS_WIDTH   (POS_WIDTH),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_req         (q_req),
        .i_stall       (i_stall),
        .o_pop         (back_pop),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_error_code  (o_error_code),
        .o_branch_kind (o_branch_kind),
        .o_cond_start  (o_cond_start),
        .o_cond_end    (o_cond_end),
        .o_true_start  (o_true_start),
        .o_true_end    (o_true_end),
        .o_false_start (o_false_start),
        .o_false_end   (o_false_end)
    );

endmodule

// ===== test/tb_if_statement_recognizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_if_statement_recognizer: self-checking bench for the if recognizer
// Streams source characters and restart requests into the recognizer and
// compares every result against an in-bench scanner model. Walks a short
// directed list first, then random if/else statements (clean, broken at
// each stage, nested past the counter limit) mixed with raw noise. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_if_statement_recognizer;
    import irec_pkg::*;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_RESTART;
    logic [7:0]  i_symbol = 8'h00;
    logic [15:0] i_position = 16'h0000;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_error_code;
    logic [1:0]  o_branch_kind;
    logic [15:0] o_cond_start;
    logic [15:0] o_cond_end;
    logic [15:0] o_true_start;
    logic [15:0] o_true_end;
    logic [15:0] o_false_start;
    logic [15:0] o_false_end;

    if_statement_recognizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_error_code  (o_error_code),
        .o_branch_kind (o_branch_kind),
        .o_cond_start  (o_cond_start),
        .o_cond_end    (o_cond_end),
        .o_true_start  (o_true_start),
        .o_true_end    (o_true_end),
        .o_false_start (o_false_start),
        .o_false_end   (o_false_end)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Result as seen after one request
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  err;
        logic [1:0]  branch;
        logic [15:0] cond_start;
        logic [15:0] cond_end;
        logic [15:0] true_start;
        logic [15:0] true_end;
        logic [15:0] false_start;
        logic [15:0] false_end;
    } t_scan_view;

    t_scan_view awaited_views[$];    // predicted results, oldest first

    // ------------------------------------------------------------------
    // Scanner model state (default widths: 16-bit positions, 8-bit depths)
    // ------------------------------------------------------------------
    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    t_scope      scope_q;
    logic        marker_on;          // main marker past leading whitespace
    logic [15:0] tok_pos;            // start of current token
    logic [15:0] lead_pair;          // first two chars of keyword token
    logic        cond_open;
    logic [7:0]  paren_cnt;
    t_tmode      tmode_q;
    logic [7:0]  tbrace_cnt;
    logic        fmode_on;
    logic [7:0]  fbrace_cnt;
    logic [15:0] bound_q [BD_COUNT];
    logic [1:0]  branch_q;
    logic [1:0]  status_q;
    logic [2:0]  err_q;

    // bookkeeping
    int          fail_count = 0;
    int          live_items = 0;     // requests the scanner actually acted on
    int          all_items = 0;
    int          results_seen = 0;
    logic [7:0]  err_seen = '0;
    logic [2:0]  branch_seen = '0;
    logic        tx_quiet = 1'b0;    // sender runs back to back this sequence
    logic [15:0] cursor;             // next source position to scan

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic void reset_scanner(input logic [15:0] pos);
        scope_q    = SC_KEY;
        marker_on  = 1'b0;
        tok_pos    = pos;
        lead_pair  = '0;
        cond_open  = 1'b0;
        paren_cnt  = '0;
        tmode_q    = TM_IDLE;
        tbrace_cnt = '0;
        fmode_on   = 1'b0;
        fbrace_cnt = '0;
        for (int b = 0; b < BD_COUNT; b++) bound_q[b] = '0;
        branch_q   = BR_UNDEF;
        status_q   = ST_NOT_FOUND;
        err_q      = ERR_NONE;
    endfunction

    // keyword: two stored chars, then blank or '(' at offset 2
    function automatic void keyword_step(input logic [7:0] c, input logic [15:0] pos);
        logic [15:0] off;
        off = pos - tok_pos;
        if (off == 16'd0) lead_pair[7:0] = c;
        else if (off == 16'd1) lead_pair[15:8] = c;
        if ((is_blank(c) || c == CH_LPAREN) && off == 16'd2 &&
            lead_pair[7:0] == CH_I && lead_pair[15:8] == CH_F) begin
            tok_pos   = pos;
            marker_on = 1'b0;
            scope_q   = SC_COND;
            status_q  = ST_FOUND;
        end
    endfunction

    function automatic void cond_step(input logic [7:0] c, input logic [15:0] pos);
        if (c == CH_LPAREN) begin
            if (paren_cnt == DEPTH_MAX) begin
                err_q = ERR_TOO_DEEP;
                return;
            end
            if (!cond_open) begin
                bound_q[BD_COND_START] = pos + 16'd1;
                cond_open = 1'b1;
            end
            paren_cnt = paren_cnt + 8'd1;
            return;
        end
        if (c == CH_RPAREN) begin
            if (!cond_open) begin
                err_q = ERR_RPAREN;
                return;
            end
            paren_cnt = paren_cnt - 8'd1;
            if (paren_cnt == 8'd0) begin
                bound_q[BD_COND_END] = pos;
                tok_pos   = pos + 16'd1;
                marker_on = 1'b0;
                scope_q   = SC_TRUE;
            end
            return;
        end
        if (!is_blank(c) && !cond_open) err_q = ERR_AFTER_IF;
    endfunction

    function automatic void true_step(input logic [7:0] c, input logic [15:0] pos);
        if (c == CH_LBRACE && tmode_q != TM_CLOSED) begin
            if (tbrace_cnt == DEPTH_MAX) begin
                err_q = ERR_TOO_DEEP;
                return;
            end
            if (tmode_q == TM_IDLE) begin
                bound_q[BD_TRUE_START] = pos;
                tmode_q = TM_OPEN;
            end
            tbrace_cnt = tbrace_cnt + 8'd1;
        end
        if (c == CH_RBRACE) begin
            if (tmode_q == TM_IDLE) begin
                err_q = ERR_RBRACE_TRUE;
                return;
            end
            if (tmode_q == TM_OPEN) begin
                tbrace_cnt = tbrace_cnt - 8'd1;
                if (tbrace_cnt == 8'd0) begin
                    bound_q[BD_TRUE_END] = pos + 16'd1;
                    tmode_q = TM_CLOSED;
                    return;
                end
            end
        end
        if (!is_blank(c)) begin
            if (tmode_q == TM_IDLE) begin
                err_q = ERR_AFTER_COND;
                return;
            end
            // first non-blank after the true body decides the branch kind
            if (tmode_q == TM_CLOSED) begin
                if (c == CH_COLON) begin
                    branch_q = BR_TRUE_FALSE;
                    scope_q  = SC_FALSE;
                end else begin
                    branch_q = BR_TRUE_ONLY;
                    scope_q  = SC_WEAVE;
                    status_q = ST_READY;
                end
                tok_pos   = pos + 16'd1;
                marker_on = 1'b0;
            end
        end
    endfunction

    function automatic void false_step(input logic [7:0] c, input logic [15:0] pos);
        if (c == CH_LBRACE) begin
            if (fbrace_cnt == DEPTH_MAX) begin
                err_q = ERR_TOO_DEEP;
                return;
            end
            if (!fmode_on) begin
                bound_q[BD_FALSE_START] = pos;
                fmode_on = 1'b1;
            end
            fbrace_cnt = fbrace_cnt + 8'd1;
        end
        if (c == CH_RBRACE) begin
            if (!fmode_on) begin
                err_q = ERR_RBRACE_FALS;
                return;
            end
            fbrace_cnt = fbrace_cnt - 8'd1;
            if (fbrace_cnt == 8'd0) begin
                bound_q[BD_FALSE_END] = pos + 16'd1;
                scope_q   = SC_WEAVE;
                status_q  = ST_READY;
                tok_pos   = pos + 16'd1;
                marker_on = 1'b0;
            end
        end
        if (!is_blank(c) && !fmode_on) err_q = ERR_BEFORE_FALS;
    endfunction

    // advance the model by one request and return the result it shows
    function automatic t_scan_view scan_step(input logic cmd, input logic [7:0] c,
                                             input logic [15:0] pos);
        t_scan_view v;
        if (cmd == CMD_RESTART) begin
            reset_scanner(pos);
        end else if (err_q == ERR_NONE) begin
            if (!marker_on) begin
                if (is_blank(c)) tok_pos = tok_pos + 16'd1;
                else marker_on = 1'b1;
            end
            if (marker_on) begin
                if (scope_q == SC_KEY) keyword_step(c, pos);
                // keyword end falls straight into condition scope
                if (scope_q == SC_COND) cond_step(c, pos);
                else if (scope_q == SC_TRUE) true_step(c, pos);
                else if (scope_q == SC_FALSE) false_step(c, pos);
            end
        end
        v.status      = status_q;
        v.err         = err_q;
        v.branch      = branch_q;
        v.cond_start  = bound_q[BD_COND_START];
        v.cond_end    = bound_q[BD_COND_END];
        v.true_start  = bound_q[BD_TRUE_START];
        v.true_end    = bound_q[BD_TRUE_END];
        v.false_start = bound_q[BD_FALSE_START];
        v.false_end   = bound_q[BD_FALSE_END];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (tx_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // send one request, wait for the handshake, then log its prediction;
    // typed rows replace the predicted codes with hand-written ones
    task automatic issue(input logic cmd, input logic [7:0] sym, input logic [15:0] pos,
                         input logic typed, input logic [6:0] typed_codes);
        int         gap;
        t_scan_view v;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_symbol   <= sym;
        i_position <= pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // requests swallowed by a latched error do not count as coverage
        if (cmd == CMD_RESTART || err_q == ERR_NONE) live_items++;
        all_items++;
        v = scan_step(cmd, sym, pos);
        if (typed) {v.status, v.err, v.branch} = typed_codes;
        awaited_views.push_back(v);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // any non-blank byte other than the two given
    function automatic logic [7:0] plain_char(input logic [7:0] bar_a, input logic [7:0] bar_b);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == bar_a || c == bar_b);
        return c;
    endfunction

    function automatic logic [7:0] syntax_char();
        case ($urandom_range(0, 7))
            0: return CH_I;
            1: return CH_F;
            2: return CH_LPAREN;
            3: return CH_RPAREN;
            4: return CH_LBRACE;
            5: return CH_RBRACE;
            6: return CH_COLON;
            default: return blank_char();
        endcase
    endfunction

    task automatic put(input logic [7:0] c);
        issue(CMD_SCAN, c, cursor, 1'b0, '0);
        cursor = cursor + 16'd1;
    endtask

    task automatic put_blanks(input int most);
        repeat ($urandom_range(0, most)) put(blank_char());
    endtask

    task automatic put_tail(input int most);
        repeat ($urandom_range(0, most)) put(8'($urandom_range(0, 255)));
    endtask

    // body after its opener: random content with balanced nesting, closed out
    task automatic put_nested(input logic [7:0] open_c, input logic [7:0] close_c,
                              input int len);
        int lvl;
        int r;
        lvl = 1;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12 && lvl < 4) begin
                put(open_c);
                lvl++;
            end else if (r < 24 && lvl > 1) begin
                put(close_c);
                lvl--;
            end else if (r < 40) begin
                put(blank_char());
            end else begin
                put(plain_char(open_c, close_c));
            end
        end
        repeat (lvl) put(close_c);
    endtask

    // one if statement from a restart on; flaw is the error code to provoke
    // at its stage (none for ERR_NONE), deep_at names the part (1 condition,
    // 2 true body, 3 false body) that is nested one past the counter limit
    task automatic put_statement(input logic [2:0] flaw, input int deep_at);
        logic [15:0] start;
        if ($urandom_range(0, 3) == 0) start = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        else start = 16'($urandom_range(0, 16'hFFFF));
        issue(CMD_RESTART, 8'($urandom_range(0, 255)), start, 1'b0, '0);
        cursor = start;
        put_blanks(3);
        put(CH_I);
        put(CH_F);
        if (flaw == ERR_RPAREN || flaw == ERR_AFTER_IF || $urandom_range(0, 1)) begin
            put(blank_char());
            put_blanks(2);
            if (flaw == ERR_RPAREN) begin
                put(CH_RPAREN);
                put_tail(2);
                return;
            end
            if (flaw == ERR_AFTER_IF) begin
                put(plain_char(CH_LPAREN, CH_RPAREN));
                put_tail(2);
                return;
            end
        end
        put(CH_LPAREN);
        if (deep_at == 1) begin
            repeat (255) put(CH_LPAREN);
            put_tail(2);
            return;
        end
        put_nested(CH_LPAREN, CH_RPAREN, $urandom_range(0, 10));
        put_blanks(3);
        if (flaw == ERR_RBRACE_TRUE || flaw == ERR_AFTER_COND) begin
            put(flaw == ERR_RBRACE_TRUE ? CH_RBRACE : plain_char(CH_LBRACE, CH_RBRACE));
            put_tail(2);
            return;
        end
        put(CH_LBRACE);
        if (deep_at == 2) begin
            repeat (255) put(CH_LBRACE);
            put_tail(2);
            return;
        end
        put_nested(CH_LBRACE, CH_RBRACE, $urandom_range(0, 12));
        put_blanks(3);
        if (flaw == ERR_RBRACE_FALS || flaw == ERR_BEFORE_FALS || deep_at == 3 ||
            $urandom_range(0, 1)) begin
            put(CH_COLON);
            put_blanks(3);
            if (flaw == ERR_RBRACE_FALS || flaw == ERR_BEFORE_FALS) begin
                put(flaw == ERR_RBRACE_FALS ? CH_RBRACE : plain_char(CH_LBRACE, CH_RBRACE));
                put_tail(2);
                return;
            end
            put(CH_LBRACE);
            if (deep_at == 3) begin
                repeat (255) put(CH_LBRACE);
                put_tail(2);
                return;
            end
            put_nested(CH_LBRACE, CH_RBRACE, $urandom_range(0, 12));
        end else begin
            // any non-blank but ':' closes a true-only statement
            put(plain_char(CH_COLON, CH_COLON));
        end
        put_tail(4);
    endtask

    // raw noise: random commands, bytes and positions, some of them jumps
    task automatic put_noise();
        logic        cmd;
        logic [15:0] p;
        repeat ($urandom_range(4, 16)) begin
            cmd = ($urandom_range(0, 5) == 0) ? CMD_RESTART : CMD_SCAN;
            if ($urandom_range(0, 9) < 3) p = 16'($urandom_range(0, 16'hFFFF));
            else p = cursor;
            issue(cmd, $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : syntax_char(), p,
                  1'b0, '0);
            cursor = p + 16'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Directed list: a full if/else with nested condition, then a wrapped
    // keyword ending in a ')' error that must stay sticky. Codes are typed
    // in where they are obvious; bounds always come from the model.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        cmd;
        logic [7:0]  sym;
        logic [15:0] pos;
        logic        typed;
        logic [1:0]  st;
        logic [2:0]  err;
        logic [1:0]  br;
    } t_probe_row;

    localparam int N_PROBES = 25;
    localparam t_probe_row PROBES [0:N_PROBES-1] = '{
        '{CMD_RESTART, 8'h00,     16'd100,   1'b1, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_SPACE,  16'd100,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_I,      16'd101,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_F,      16'd102,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_LPAREN, 16'd103,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_LPAREN, 16'd104,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    8'h78,     16'd105,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_RPAREN, 16'd106,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_RPAREN, 16'd107,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_TAB,    16'd108,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_LBRACE, 16'd109,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_RBRACE, 16'd110,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_COLON,  16'd111,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_LF,     16'd112,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_LBRACE, 16'd113,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_CR,     16'd114,   1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_RBRACE, 16'd115,   1'b1, ST_READY, ERR_NONE, BR_TRUE_FALSE},
        '{CMD_RESTART, 8'hFF,     16'hFFFE,  1'b1, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_I,      16'hFFFE,  1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_F,      16'hFFFF,  1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_SPACE,  16'h0000,  1'b1, ST_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_RPAREN, 16'h0001,  1'b1, ST_FOUND, ERR_RPAREN, BR_UNDEF},
        '{CMD_SCAN,    8'hFF,     16'h0002,  1'b1, ST_FOUND, ERR_RPAREN, BR_UNDEF},
        '{CMD_RESTART, 8'h00,     16'hFFFF,  1'b1, ST_NOT_FOUND, ERR_NONE, BR_UNDEF},
        '{CMD_SCAN,    CH_I,      16'hFFFF,  1'b0, ST_NOT_FOUND, ERR_NONE, BR_UNDEF}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          random_base;
        int          seq;
        int          pick;
        int          spins;
        reset_scanner(16'd0);
        cursor = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_PROBES; k++)
            issue(PROBES[k].cmd, PROBES[k].sym, PROBES[k].pos, PROBES[k].typed,
                  {PROBES[k].st, PROBES[k].err, PROBES[k].br});

        // random part: mostly well-formed statements, the rest broken ones
        // and noise; three sequences push one counter past its limit
        random_base = all_items;
        seq = 0;
        while (all_items - random_base < 1400 || seq < 24) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (seq == 3) put_statement(ERR_NONE, 1);
            else if (seq == 9) put_statement(ERR_NONE, 2);
            else if (seq == 15) put_statement(ERR_NONE, 3);
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) put_statement(ERR_NONE, 0);
                else if (pick < 85) put_statement(3'($urandom_range(1, 6)), 0);
                else put_noise();
            end
            seq++;
        end
        // last request was taken at this edge; stop offering
        i_valid <= 1'b0;

        spins = 0;
        while (awaited_views.size() != 0 && spins < 100000) begin
            @(posedge i_clk);
            spins++;
        end
        if (awaited_views.size() != 0) begin
            $error("%0d results never arrived", awaited_views.size());
            fail_count++;
        end
        // give a stray extra result time to show up
        repeat (16) @(posedge i_clk);

        $display("covered %0d requests (%0d acted on), %0d results checked",
                 all_items, live_items, results_seen);
        $display("error codes seen %b, branch kinds seen %b", err_seen, branch_seen);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: compare against the oldest prediction, random stalls
    // ------------------------------------------------------------------
    task automatic check_view(input t_scan_view want);
        if (o_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, o_status);
            fail_count++;
        end
        if (o_error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, o_error_code);
            fail_count++;
        end
        if (o_branch_kind !== want.branch) begin
            $error("branch_kind: expected %0d, got %0d", want.branch, o_branch_kind);
            fail_count++;
        end
        if (o_cond_start !== want.cond_start) begin
            $error("cond_start: expected %0d, got %0d", want.cond_start, o_cond_start);
            fail_count++;
        end
        if (o_cond_end !== want.cond_end) begin
            $error("cond_end: expected %0d, got %0d", want.cond_end, o_cond_end);
            fail_count++;
        end
        if (o_true_start !== want.true_start) begin
            $error("true_start: expected %0d, got %0d", want.true_start, o_true_start);
            fail_count++;
        end
        if (o_true_end !== want.true_end) begin
            $error("true_end: expected %0d, got %0d", want.true_end, o_true_end);
            fail_count++;
        end
        if (o_false_start !== want.false_start) begin
            $error("false_start: expected %0d, got %0d", want.false_start, o_false_start);
            fail_count++;
        end
        if (o_false_end !== want.false_end) begin
            $error("false_end: expected %0d, got %0d", want.false_end, o_false_end);
            fail_count++;
        end
        err_seen[want.err]       = 1'b1;
        branch_seen[want.branch] = 1'b1;
    endtask

    int   stall_left = 0;
    int   phase_left = 0;
    logic rx_quiet = 1'b0;

    always @(posedge i_clk) begin : result_check
        t_scan_view want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_views.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = awaited_views.pop_front();
                    check_view(want);
                    results_seen++;
                end
            end
            // alternate stretches of free flow with stretches of stalls
            if (phase_left == 0) begin
                rx_quiet   = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 300);
            end else begin
                phase_left--;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
                i_stall <= 1'b1;
                if ($urandom_range(0, 99) < 85) stall_left = $urandom_range(0, 2);
                else stall_left = $urandom_range(9, 39);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
design/irec_pkg.sv
design/irec_front.sv
design/irec_queue.sv
design/irec_back.sv
design/if_statement_recognizer.sv
test/tb_if_statement_recognizer.sv
